// ===== design/wdf_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by the design modules and the checker.
package wdf_pkg;

  // Parser phase. The mask phases are consecutive so the low bits pick the byte.
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_LEN    = 4'd1,
    PH_EXT_HI = 4'd2,
    PH_EXT_LO = 4'd3,
    PH_MASK0  = 4'd4,
    PH_MASK1  = 4'd5,
    PH_MASK2  = 4'd6,
    PH_MASK3  = 4'd7,
    PH_DATA   = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    ST_PAYLOAD = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_LONG    = 2'd2,
    ST_ABORT   = 2'd3
  } status_t;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam int         MASK_BYTES = 4;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        link_down;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [7:0]  frame_header;
    logic [15:0] payload_position;
    logic        last;
    status_t     status;
  } res_item_t;

endpackage

// ===== design/wdf_in_if.sv =====
// Input byte channel: valid/ready handshake carrying one received byte.
// Depends on nothing beyond the handshake convention.
interface wdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       link_down;

  modport source (output valid, output rx_byte, output link_down, input ready);
  modport sink   (input valid, input rx_byte, input link_down, output ready);
endinterface

// ===== design/wdf_out_if.sv =====
// Result channel: valid/ready handshake carrying one deframer result.
// Declares its status field with the width of status_t in wdf_pkg.
interface wdf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic [7:0]  frame_header;
  logic [15:0] payload_position;
  logic        last;
  logic [1:0]  status;

  modport source (output valid, output payload_byte, output frame_header,
                  output payload_position, output last, output status, input ready);
  modport sink   (input valid, input payload_byte, input frame_header,
                  input payload_position, input last, input status, output ready);
endinterface

// ===== design/websocket_frame_deframer.sv =====
// Top level of the WebSocket frame deframer: parser plus output buffer.
// Depends on wdf_pkg, wdf_in_if, wdf_out_if, wdf_parser and wdf_out_buf.
//
// Receives one byte per transaction and parses WebSocket frames with 7-bit or
// 16-bit lengths, emitting each payload byte unmasked along with the frame
// header, its position and a last flag; empty frames, 64-bit length codes
// (unsupported) and link-down aborts during a frame each give one status
// result. A byte is accepted every cycle unless the input stalls: the parser
// forms each result and its mask XOR combinationally, straight into the buffer. A
// result register plus one skid entry lets input continue while a result
// waits; the input stalls only when both are full. LENGTH_BITS sets the
// width of the length and position counters; longer lengths saturate.
module websocket_frame_deframer #(
  parameter int LENGTH_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  wdf_in_if.sink    in_ch,
  wdf_out_if.source out_ch
);
  import wdf_pkg::*;

  logic      accept;
  logic      res_valid;
  logic      buf_ready;
  in_item_t  in_item;
  res_item_t res_item;
  res_item_t out_item;

  assign in_ch.ready = buf_ready;
  assign accept      = in_ch.valid && buf_ready;
  assign in_item     = '{rx_byte: in_ch.rx_byte, link_down: in_ch.link_down};

  wdf_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  wdf_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && res_valid),
    .push_item (res_item),
    .in_ready  (buf_ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign out_ch.payload_byte     = out_item.payload_byte;
  assign out_ch.frame_header     = out_item.frame_header;
  assign out_ch.payload_position = out_item.payload_position;
  assign out_ch.last             = out_item.last;
  assign out_ch.status           = out_item.status;

endmodule

// ===== design/wdf_parser.sv =====
// Frame parser: phase register, header/length/mask state and unmasking XOR.
// Produces at most one result per accepted byte. Depends on wdf_pkg.
module wdf_parser #(
  parameter int LENGTH_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  wdf_pkg::in_item_t  in_item,
  output logic               res_valid,
  output wdf_pkg::res_item_t res_item
);
  import wdf_pkg::*;

  localparam int          LEN_W   = LENGTH_BITS;
  localparam logic [15:0] LEN_MAX = 16'((32'd1 << LENGTH_BITS) - 32'd1);

  phase_t           phase_r, phase_nxt;
  logic [7:0]       header_r, header_nxt;
  logic             masked_r, masked_nxt;
  logic [7:0]       mask_r [MASK_BYTES];
  logic [7:0]       mask_nxt [MASK_BYTES];
  logic [7:0]       ext_hi_r, ext_hi_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;

  logic [7:0]       b;
  logic [6:0]       len7;
  logic [15:0]      ext_len;
  logic [LEN_W-1:0] ext_sat;

  assign b       = in_item.rx_byte;
  assign len7    = b[6:0];
  assign ext_len = {ext_hi_r, b};
  assign ext_sat = (ext_len > LEN_MAX) ? '1 : ext_len[LEN_W-1:0];

  always_comb begin
    phase_nxt  = phase_r;
    header_nxt = header_r;
    masked_nxt = masked_r;
    ext_hi_nxt = ext_hi_r;
    rem_nxt    = rem_r;
    pos_nxt    = pos_r;
    for (int i = 0; i < MASK_BYTES; i++) begin
      mask_nxt[i] = mask_r[i];
    end
    res_valid                 = 1'b0;
    res_item.payload_byte     = 8'd0;
    res_item.frame_header     = header_r;
    res_item.payload_position = 16'd0;
    res_item.last             = 1'b1;
    res_item.status           = ST_EMPTY;

    if (in_item.link_down) begin
      if (phase_r != PH_IDLE) begin
        phase_nxt                 = PH_IDLE;
        res_valid                 = 1'b1;
        res_item.payload_position = 16'(pos_r);
        res_item.status           = ST_ABORT;
      end
    end else begin
      case (phase_r)
        PH_IDLE: begin
          header_nxt = b;
          masked_nxt = 1'b0;
          rem_nxt    = '0;
          pos_nxt    = '0;
          phase_nxt  = PH_LEN;
        end
        PH_LEN: begin
          masked_nxt = b[7];
          if (len7 == LEN7_EXT64) begin
            phase_nxt       = PH_IDLE;
            res_valid       = 1'b1;
            res_item.status = ST_LONG;
          end else if (len7 == LEN7_EXT16) begin
            phase_nxt = PH_EXT_HI;
          end else begin
            rem_nxt = LEN_W'(len7);
            if (b[7]) begin
              phase_nxt = PH_MASK0;
            end else if (len7 == 7'd0) begin
              phase_nxt = PH_IDLE;
              res_valid = 1'b1;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_EXT_HI: begin
          ext_hi_nxt = b;
          phase_nxt  = PH_EXT_LO;
        end
        PH_EXT_LO: begin
          rem_nxt = ext_sat;
          if (masked_r) begin
            phase_nxt = PH_MASK0;
          end else if (ext_len == 16'd0) begin
            phase_nxt = PH_IDLE;
            res_valid = 1'b1;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_MASK0, PH_MASK1, PH_MASK2: begin
          mask_nxt[phase_r[1:0]] = b;
          phase_nxt              = phase_t'(phase_r + 4'd1);
        end
        PH_MASK3: begin
          mask_nxt[MASK_BYTES-1] = b;
          if (rem_r == '0) begin
            phase_nxt = PH_IDLE;
            res_valid = 1'b1;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          res_valid                 = 1'b1;
          res_item.payload_byte     = masked_r ? (b ^ mask_r[pos_r[1:0]]) : b;
          res_item.payload_position = 16'(pos_r);
          res_item.last             = (rem_r == LEN_W'(1));
          res_item.status           = ST_PAYLOAD;
          rem_nxt                   = rem_r - LEN_W'(1);
          pos_nxt                   = pos_r + LEN_W'(1);
          if (rem_r == LEN_W'(1)) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (accept) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= 8'd0;
      masked_r <= 1'b0;
      ext_hi_r <= 8'd0;
      rem_r    <= '0;
      pos_r    <= '0;
      for (int i = 0; i < MASK_BYTES; i++) begin
        mask_r[i] <= 8'd0;
      end
    end else if (accept) begin
      header_r <= header_nxt;
      masked_r <= masked_nxt;
      ext_hi_r <= ext_hi_nxt;
      rem_r    <= rem_nxt;
      pos_r    <= pos_nxt;
      for (int i = 0; i < MASK_BYTES; i++) begin
        mask_r[i] <= mask_nxt[i];
      end
    end
  end

endmodule

// ===== design/wdf_out_buf.sv =====
// Result register with a skid entry, so a byte is taken while a result waits.
// Depends on wdf_pkg for the result type.
module wdf_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  wdf_pkg::res_item_t push_item,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output wdf_pkg::res_item_t out_item
);
  import wdf_pkg::*;

  logic      main_v_r, skid_v_r;
  res_item_t main_r, skid_r;

  assign in_ready  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_item  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || out_ready) begin
      // no push can coincide with a full skid since in_ready is low then
      if (skid_v_r) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v_r || out_ready) begin
      main_r <= skid_v_r ? skid_r : push_item;
    end else if (push) begin
      skid_r <= push_item;
    end
  end

endmodule

// ===== design/wdf_checker.sv =====
// Port-level checks for the deframer and the bind that attaches them.
// Depends on wdf_pkg status codes and the top level's interface ports.
module wdf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  payload_byte,
  input logic [15:0] payload_position,
  input logic        last,
  input logic [1:0]  status
);
  import wdf_pkg::*;

  // a stalled result must stay valid and keep its byte and status
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte) && $stable(status))
    else $error("result changed while stalled");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_PAYLOAD |-> last)
    else $error("status result not marked last");

  a_status_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_PAYLOAD |-> payload_byte == 8'd0)
    else $error("status result carries data");

  a_empty_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_EMPTY || status == ST_LONG) |-> payload_position == 16'd0)
    else $error("empty or long result has nonzero position");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind websocket_frame_deframer wdf_checker u_wdf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .payload_byte     (out_ch.payload_byte),
  .payload_position (out_ch.payload_position),
  .last             (out_ch.last),
  .status           (out_ch.status)
);
